[src/double_ended_queue_assert.svh]
// Assertion macros for the double-ended queue RTL
`ifndef DOUBLE_ENDED_QUEUE_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_ASSERT_SVH

// Check that the consequent holds in the same cycle as the antecedent
`define DQ_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check that the consequent holds in the cycle after the antecedent
`define DQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/dq_pkg.sv]
// Shared constants, types and ring helpers for the double-ended queue
package dq_pkg;

  localparam int DEPTH       = 64;
  localparam int PTR_W       = $clog2(DEPTH);
  localparam int CNT_W       = $clog2(DEPTH + 1);
  localparam int DATA_W      = 32;
  localparam int MODE_W      = 3;
  localparam int STATUS_W    = 2;
  localparam int COUNT_OUT_W = 7;
  localparam int S_TDATA_W   = 40;
  localparam int M_TDATA_W   = 48;

  // Field positions in the result word
  localparam int STATUS_LSB = DATA_W;
  localparam int COUNT_LSB  = DATA_W + STATUS_W;
  localparam int PAD_W      = M_TDATA_W - COUNT_LSB - COUNT_OUT_W;

  localparam logic [PTR_W-1:0]       PTR_LAST       = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0]       CNT_FULL       = CNT_W'(DEPTH);
  localparam logic [COUNT_OUT_W-1:0] COUNT_FULL_OUT = COUNT_OUT_W'(DEPTH);

  typedef enum logic [MODE_W-1:0] {
    MODE_PUSH_FRONT = 3'd0,
    MODE_PUSH_BACK  = 3'd1,
    MODE_POP_FRONT  = 3'd2,
    MODE_POP_BACK   = 3'd3,
    MODE_PEEK_FRONT = 3'd4,
    MODE_PEEK_BACK  = 3'd5,
    MODE_CLEAR      = 3'd6
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_code_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_DONE
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic exec;
    logic finish;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic             out_free;
    logic [CNT_W-1:0] held;
  } dp_stat_t;

  function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] i);
    return (i == PTR_LAST) ? '0 : i + PTR_W'(1);
  endfunction

  function automatic logic [PTR_W-1:0] ring_prev(input logic [PTR_W-1:0] i);
    return (i == '0) ? PTR_LAST : i - PTR_W'(1);
  endfunction

endpackage

[src/dq_datapath.sv]
// Ring store, pointers, entry count and result register of the queue
module dq_datapath
  import dq_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  dp_cmd_t              cmd,
  output dp_stat_t             stat,
  input  logic [MODE_W-1:0]    in_mode,
  input  logic [DATA_W-1:0]    in_value,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [M_TDATA_W-1:0] out_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  mode_t             op;
  logic [DATA_W-1:0] op_value;
  logic [PTR_W-1:0]  head, head_next;
  logic [PTR_W-1:0]  tail, tail_next;
  logic [CNT_W-1:0]  held, held_next;
  status_code_t      res_status, status_next;
  logic              use_rd, use_rd_next;
  logic [DATA_W-1:0] rd_data;
  logic              wr_en, rd_en;
  logic [PTR_W-1:0]  wr_addr, rd_addr;
  logic [DATA_W-1:0] res_value;
  logic [31:0]       held_wide;

  // Decide the effect of the held operation on the ring
  always_comb begin
    head_next   = head;
    tail_next   = tail;
    held_next   = held;
    status_next = STAT_OK;
    use_rd_next = 1'b0;
    wr_en       = 1'b0;
    rd_en       = 1'b0;
    wr_addr     = tail;
    rd_addr     = head;
    case (op)
      MODE_PUSH_FRONT: begin
        if (held == CNT_FULL) begin
          status_next = STAT_FULL;
        end else begin
          head_next = ring_prev(head);
          wr_addr   = ring_prev(head);
          wr_en     = 1'b1;
          held_next = held + CNT_W'(1);
        end
      end
      MODE_PUSH_BACK: begin
        if (held == CNT_FULL) begin
          status_next = STAT_FULL;
        end else begin
          wr_addr   = tail;
          wr_en     = 1'b1;
          tail_next = ring_next(tail);
          held_next = held + CNT_W'(1);
        end
      end
      MODE_POP_FRONT: begin
        if (held == '0) begin
          status_next = STAT_EMPTY;
        end else begin
          rd_addr     = head;
          rd_en       = 1'b1;
          use_rd_next = 1'b1;
          head_next   = ring_next(head);
          held_next   = held - CNT_W'(1);
        end
      end
      MODE_POP_BACK: begin
        if (held == '0) begin
          status_next = STAT_EMPTY;
        end else begin
          rd_addr     = ring_prev(tail);
          rd_en       = 1'b1;
          use_rd_next = 1'b1;
          tail_next   = ring_prev(tail);
          held_next   = held - CNT_W'(1);
        end
      end
      MODE_PEEK_FRONT: begin
        if (held == '0) begin
          status_next = STAT_EMPTY;
        end else begin
          rd_addr     = head;
          rd_en       = 1'b1;
          use_rd_next = 1'b1;
        end
      end
      MODE_PEEK_BACK: begin
        if (held == '0) begin
          status_next = STAT_EMPTY;
        end else begin
          rd_addr     = ring_prev(tail);
          rd_en       = 1'b1;
          use_rd_next = 1'b1;
        end
      end
      MODE_CLEAR: begin
        head_next = '0;
        tail_next = '0;
        held_next = '0;
      end
      default: begin
      end
    endcase
  end

  // Capture the incoming item
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op       <= mode_t'(in_mode);
      op_value <= in_value;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      tail <= '0;
      held <= '0;
    end else if (cmd.exec) begin
      head <= head_next;
      tail <= tail_next;
      held <= held_next;
    end
  end

  // Hold the outcome until the result register is free
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      res_status <= status_next;
      use_rd     <= use_rd_next;
    end
  end

  // Ring store, one write or one registered read per operation
  always_ff @(posedge clk) begin
    if (cmd.exec && wr_en) begin
      mem[wr_addr] <= op_value;
    end
    if (cmd.exec && rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  assign res_value = use_rd ? rd_data : '0;
  assign held_wide = 32'(held);

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_data <= {{PAD_W{1'b0}}, held_wide[COUNT_OUT_W-1:0], res_status, res_value};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  assign stat.out_free = !out_valid || out_ready;
  assign stat.held     = held;

endmodule

[src/dq_controller.sv]
// Sequencing state machine of the double-ended queue
module dq_controller
  import dq_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_EXEC;
      end
      S_EXEC: begin
        state_next = S_DONE;
      end
      S_DONE: begin
        if (stat.out_free) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Commands
  always_comb begin
    in_ready   = 1'b0;
    cmd.load   = 1'b0;
    cmd.exec   = 1'b0;
    cmd.finish = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
      end
      S_DONE: begin
        cmd.finish = stat.out_free;
      end
      default: begin
      end
    endcase
  end

endmodule

[src/double_ended_queue.sv]
// Double-ended queue of signed 32-bit values over a ring store
//
// Input channel s_*: one operation per transfer (push or pop at either end,
// peek at either end, clear) with the value to push. Output channel m_*:
// exactly one result per operation, carrying the popped or peeked value,
// a status code (ok, empty, full) and the entry count after the operation.
// A pop or peek on an empty queue returns zero with status empty; a push
// on a full queue is dropped with status full.
//
// The input transfer is captured, the ring is accessed through its
// registered read port, then the result is loaded into the output
// register once that is free. A new operation is taken only after the
// previous one has loaded its result (capture/execute/load sequence).
//
// Reset empties the queue (pointers and count to zero) and drops any
// pending result; store contents are not cleared. When the receiver
// stalls, the result holds in the output register and the next operation
// may still be taken and executed; it then waits to load its result.
module double_ended_queue
  import dq_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,  // mode[2:0], data_value[34:3], zero pad
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata   // result_value[31:0], status[33:32],
                                         // entry_count[40:34], zero pad
);

  `include "double_ended_queue_assert.svh"

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  logic in_xfer;
  logic res_full, res_empty;
  logic full_ok, empty_ok;

  dq_controller u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .stat     (dp_stat),
    .cmd      (dp_cmd)
  );

  dq_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (dp_cmd),
    .stat      (dp_stat),
    .in_mode   (s_tdata[MODE_W-1:0]),
    .in_value  (s_tdata[MODE_W +: DATA_W]),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata)
  );

  // Decode the presented result for the checks below
  assign in_xfer   = s_tvalid && s_tready;
  assign res_full  = m_tvalid && (m_tdata[STATUS_LSB +: STATUS_W] == STAT_FULL);
  assign res_empty = m_tvalid && (m_tdata[STATUS_LSB +: STATUS_W] == STAT_EMPTY);
  assign full_ok   = (m_tdata[COUNT_LSB +: COUNT_OUT_W] == COUNT_FULL_OUT) &&
                     (m_tdata[DATA_W-1:0] == '0);
  assign empty_ok  = (m_tdata[COUNT_LSB +: COUNT_OUT_W] == '0) &&
                     (m_tdata[DATA_W-1:0] == '0);

  // Only one operation in flight at a time
  `DQ_ASSERT_NEXT(a_one_in_flight, clk, rst, in_xfer, !s_tready, "transfer taken while busy")

  // Count never exceeds the store depth
  `DQ_ASSERT_NOW(a_held_bound, clk, rst, 1'b1, dp_stat.held <= CNT_FULL, "count above depth")

  // A full status goes with a full count and a zero value
  `DQ_ASSERT_NOW(a_full_result, clk, rst, res_full, full_ok, "full status, bad result")

  // An empty status goes with a zero count and a zero value
  `DQ_ASSERT_NOW(a_empty_result, clk, rst, res_empty, empty_ok, "empty status, bad result")

endmodule

[tb/tb_double_ended_queue.sv]
// Self-checking testbench for the double-ended queue: random and directed stream traffic
`timescale 1ns / 1ps

module tb_double_ended_queue;
  import dq_pkg::*;

  localparam logic [MODE_W-1:0] MODE_UNUSED = 3'd7;
  localparam int OPS_WANTED  = 1150;
  localparam int FILL_AT     = 320;   // where the overflow segment starts
  localparam int LONG_HOLD   = 300;   // receiver back-pressure, in cycles
  localparam int QUIET_OPS   = 150;   // final stretch without idling
  localparam int STALL_LIMIT = 4000;  // cycles with no transfer before giving up
  localparam int TAIL_CYCLES = 20;

  localparam int BIAS_FILL  = 0;
  localparam int BIAS_DRAIN = 1;
  localparam int BIAS_MIXED = 2;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [DATA_W-1:0] value;
    bit                drain_first;  // wait for every outstanding result first
    bit                hold_rx;      // start the long receiver hold-off
  } deque_op_t;

  typedef struct packed {
    logic [DATA_W-1:0]      value;
    status_code_t           status;
    logic [COUNT_OUT_W-1:0] count;
  } deque_result_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;

  // Shadow deque
  logic [DATA_W-1:0] ring_mem [DEPTH];
  int ring_head = 0;
  int ring_tail = 0;
  int ring_held = 0;

  deque_op_t     op_queue[$];
  deque_result_t awaited_results[$];
  deque_op_t     cur_op;
  deque_result_t got_want;

  int  op_total = 0;
  int  ops_accepted = 0;
  int  results_seen = 0;
  int  err_cnt = 0;
  int  tx_gap = 0;
  int  rx_wait = 0;
  bit  rx_hold_go = 1'b0;
  bit  rx_hold_done = 1'b0;
  int  stall_cycles = 0;
  int  full_hits = 0;
  int  empty_hits = 0;
  int  peak_held = 0;

  double_ended_queue u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Advance the shadow deque by one operation and return its result
  function automatic deque_result_t deque_apply(input logic [MODE_W-1:0] op,
                                                input logic [DATA_W-1:0] val);
    deque_result_t r;
    r.value  = '0;
    r.status = STAT_OK;
    case (op)
      MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
        if (ring_held >= DEPTH) begin
          r.status = STAT_FULL;
          full_hits++;
        end else if (op == MODE_PUSH_FRONT) begin
          ring_head = (ring_head + DEPTH - 1) % DEPTH;
          ring_mem[ring_head] = val;
          ring_held++;
        end else begin
          ring_mem[ring_tail] = val;
          ring_tail = (ring_tail + 1) % DEPTH;
          ring_held++;
        end
      end
      MODE_POP_FRONT, MODE_POP_BACK, MODE_PEEK_FRONT, MODE_PEEK_BACK: begin
        if (ring_held == 0) begin
          r.status = STAT_EMPTY;
          empty_hits++;
        end else if (op == MODE_POP_FRONT) begin
          r.value   = ring_mem[ring_head];
          ring_head = (ring_head + 1) % DEPTH;
          ring_held--;
        end else if (op == MODE_POP_BACK) begin
          ring_tail = (ring_tail + DEPTH - 1) % DEPTH;
          r.value   = ring_mem[ring_tail];
          ring_held--;
        end else if (op == MODE_PEEK_FRONT) begin
          r.value = ring_mem[ring_head];
        end else begin
          r.value = ring_mem[(ring_tail + DEPTH - 1) % DEPTH];
        end
      end
      MODE_CLEAR: begin
        ring_head = 0;
        ring_tail = 0;
        ring_held = 0;
      end
      default: ;
    endcase
    if (ring_held > peak_held) peak_held = ring_held;
    r.count = COUNT_OUT_W'(ring_held);
    return r;
  endfunction

  task automatic add_op(input logic [MODE_W-1:0] op, input logic [DATA_W-1:0] val,
                        input bit drain, input bit hold);
    deque_op_t o;
    o.mode        = op;
    o.value       = val;
    o.drain_first = drain;
    o.hold_rx     = hold;
    op_queue.insert(op_queue.size(), o);
  endtask

  // Mostly uniform words, with the corners now and then
  function automatic logic [DATA_W-1:0] next_word();
    case ($urandom_range(0, 15))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'hFFFF_FFFF;
      3:       return 32'h0000_0000;
      default: return $urandom;
    endcase
  endfunction

  // Build the stimulus, release reset, then wait for the traffic to drain
  initial begin
    int bias;
    int seg_len;
    int roll;
    int push_cut;
    int pop_cut;
    bit fill_done;
    bit resume_drain;

    fill_done    = 1'b0;
    resume_drain = 1'b0;

    // Empty reads and the unused code on a fresh queue
    add_op(MODE_POP_FRONT, next_word(), 0, 0);
    add_op(MODE_POP_BACK, next_word(), 0, 0);
    add_op(MODE_PEEK_FRONT, next_word(), 0, 0);
    add_op(MODE_PEEK_BACK, next_word(), 0, 0);
    add_op(MODE_UNUSED, next_word(), 0, 0);
    // Extreme values at both ends
    add_op(MODE_PUSH_BACK, 32'h7FFF_FFFF, 0, 0);
    add_op(MODE_PUSH_FRONT, 32'h8000_0000, 0, 0);
    add_op(MODE_PUSH_BACK, 32'hFFFF_FFFF, 0, 0);
    add_op(MODE_PUSH_FRONT, 32'h0000_0000, 0, 0);
    add_op(MODE_PEEK_FRONT, next_word(), 0, 0);
    add_op(MODE_PEEK_BACK, next_word(), 0, 0);
    add_op(MODE_UNUSED, next_word(), 0, 0);
    add_op(MODE_POP_FRONT, next_word(), 0, 0);
    add_op(MODE_POP_BACK, next_word(), 0, 0);
    add_op(MODE_POP_FRONT, next_word(), 0, 0);
    add_op(MODE_POP_BACK, next_word(), 0, 0);
    // Clear a non-empty queue, then reuse it
    add_op(MODE_PUSH_BACK, 32'h5555_5555, 0, 0);
    add_op(MODE_PUSH_FRONT, 32'hAAAA_AAAA, 0, 0);
    add_op(MODE_CLEAR, next_word(), 0, 0);
    add_op(MODE_PEEK_BACK, next_word(), 0, 0);
    add_op(MODE_POP_FRONT, next_word(), 0, 0);
    add_op(MODE_PUSH_FRONT, 32'h0000_0001, 0, 0);
    add_op(MODE_POP_BACK, next_word(), 0, 0);

    // Random segments, each leaning towards filling, draining or neither
    while (op_queue.size() < OPS_WANTED) begin
      if (!fill_done && op_queue.size() >= FILL_AT) begin
        // Overflow run: start from empty, push past full while the receiver holds off
        add_op(MODE_CLEAR, next_word(), 1, 0);
        for (int i = 0; i < DEPTH + 6; i++)
          add_op($urandom_range(0, 1) ? MODE_PUSH_BACK : MODE_PUSH_FRONT, next_word(),
                 0, i == 0);
        add_op(MODE_PEEK_FRONT, next_word(), 0, 0);
        add_op(MODE_PEEK_BACK, next_word(), 0, 0);
        for (int i = 0; i < DEPTH + 4; i++)
          add_op($urandom_range(0, 1) ? MODE_POP_BACK : MODE_POP_FRONT, next_word(), 0, 0);
        fill_done    = 1'b1;
        resume_drain = 1'b1;
      end
      bias     = $urandom_range(BIAS_FILL, BIAS_MIXED);
      seg_len  = $urandom_range(40, 120);
      push_cut = (bias == BIAS_FILL) ? 80 : (bias == BIAS_DRAIN) ? 20 : 48;
      pop_cut  = push_cut + (98 - push_cut) * 3 / 4;
      for (int i = 0; i < seg_len && op_queue.size() < OPS_WANTED; i++) begin
        roll = $urandom_range(0, 99);
        if (roll < push_cut)
          add_op($urandom_range(0, 1) ? MODE_PUSH_BACK : MODE_PUSH_FRONT, next_word(),
                 resume_drain, 0);
        else if (roll < pop_cut)
          add_op($urandom_range(0, 1) ? MODE_POP_BACK : MODE_POP_FRONT, next_word(),
                 resume_drain, 0);
        else if (roll < 98)
          add_op($urandom_range(0, 1) ? MODE_PEEK_BACK : MODE_PEEK_FRONT, next_word(),
                 resume_drain, 0);
        else if (roll == 98)
          add_op(MODE_CLEAR, next_word(), resume_drain, 0);
        else
          add_op(MODE_UNUSED, next_word(), resume_drain, 0);
        resume_drain = 1'b0;
      end
    end
    op_total = op_queue.size();

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    while (ops_accepted < op_total || awaited_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Covered %0d deque operations and %0d results; %0d pushes refused as full,",
             ops_accepted, results_seen, full_hits);
    $display("%0d reads on an empty queue, deepest fill %0d of %0d.",
             empty_hits, peak_held, DEPTH);
    if (err_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Sender: predict each accepted transfer, then offer the next operation or idle
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata  <= '0;
    end else begin
      if (s_tvalid && s_tready) begin
        awaited_results.insert(awaited_results.size(),
                               deque_apply(cur_op.mode, cur_op.value));
        if (cur_op.hold_rx) rx_hold_go <= 1'b1;
        ops_accepted++;
      end
      if (!s_tvalid || s_tready) begin
        if (tx_gap > 0) begin
          tx_gap--;
          s_tvalid <= 1'b0;
        end else if (op_queue.size() == 0 ||
                     (op_queue[0].drain_first && awaited_results.size() != 0)) begin
          s_tvalid <= 1'b0;
        end else if (ops_accepted < op_total - QUIET_OPS && (ops_accepted / 128) % 4 != 3 &&
                     $urandom_range(0, 7) == 0) begin
          tx_gap = $urandom_range(1, 17) - 1;
          s_tvalid <= 1'b0;
        end else begin
          cur_op = op_queue[0];
          op_queue.delete(0);
          s_tvalid <= 1'b1;
          s_tdata  <= S_TDATA_W'({cur_op.value, cur_op.mode});
        end
      end
    end
  end

  // Receiver: one long hold-off on request, otherwise random bursts of back-pressure
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (rx_hold_go && !rx_hold_done) begin
        rx_hold_done = 1'b1;
        rx_wait      = LONG_HOLD;
      end
      if (rx_wait > 0) begin
        rx_wait--;
        m_tready <= 1'b0;
      end else if (results_seen < op_total - QUIET_OPS && (results_seen / 96) % 4 != 1 &&
                   $urandom_range(0, 7) == 0) begin
        rx_wait = $urandom_range(1, 17) - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Compare each result transfer against the oldest prediction
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      if (awaited_results.size() == 0) begin
        $error("result transfer with nothing outstanding: tdata %h", m_tdata);
        err_cnt++;
      end else begin
        got_want = awaited_results[0];
        awaited_results.delete(0);
        if (m_tdata[DATA_W-1:0] !== got_want.value) begin
          $error("result_value: expected %0d, got %0d",
                 $signed(got_want.value), $signed(m_tdata[DATA_W-1:0]));
          err_cnt++;
        end
        if (m_tdata[STATUS_LSB +: STATUS_W] !== got_want.status) begin
          $error("status: expected %0d, got %0d",
                 got_want.status, m_tdata[STATUS_LSB +: STATUS_W]);
          err_cnt++;
        end
        if (m_tdata[COUNT_LSB +: COUNT_OUT_W] !== got_want.count) begin
          $error("entry_count: expected %0d, got %0d",
                 got_want.count, m_tdata[COUNT_LSB +: COUNT_OUT_W]);
          err_cnt++;
        end
      end
    end
  end

  // Abort if neither side moves for too long
  always @(posedge clk) begin
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
        stall_cycles = 0;
      else
        stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Timed out after %0d idle cycles, %0d results outstanding.",
                 stall_cycles, awaited_results.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

endmodule
